>>> rtl/two_digit_seven_segment_scanner_core_defines.svh
// Assertion macros shared by the scanner's checker.
`ifndef TWO_DIGIT_SEVEN_SEGMENT_SCANNER_CORE_DEFINES_SVH
`define TWO_DIGIT_SEVEN_SEGMENT_SCANNER_CORE_DEFINES_SVH

// Check a property on every rising edge while reset is released.
`define TDSS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdss assertion failed");

// Check an implication on every rising edge while reset is released.
`define TDSS_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("tdss assertion failed");

`endif

>>> rtl/tdss_pkg.sv
`timescale 1ns / 1ps

package tdss_pkg;

    localparam int TIME_W  = 16;
    localparam int VALUE_W = 8;
    localparam int SEG_W   = 8;
    localparam int CLAMP_W = 7;
    localparam int DIGIT_W = 4;

    localparam logic [TIME_W-1:0]  INTERVAL_RESET = 16'd10000;
    localparam logic [VALUE_W-1:0] VALUE_MAX      = 8'd99;
    localparam logic [SEG_W-1:0]   SEG_DARK       = 8'hFF;

    // Segment patterns, active high, digits zero to nine.
    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        8'h77, 8'h06, 8'hB3, 8'h97, 8'hC6, 8'hD5, 8'hF5, 8'h07, 8'hF7, 8'hD7
    };

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = SEG_TABLE[0];
            4'd1:    pat = SEG_TABLE[1];
            4'd2:    pat = SEG_TABLE[2];
            4'd3:    pat = SEG_TABLE[3];
            4'd4:    pat = SEG_TABLE[4];
            4'd5:    pat = SEG_TABLE[5];
            4'd6:    pat = SEG_TABLE[6];
            4'd7:    pat = SEG_TABLE[7];
            4'd8:    pat = SEG_TABLE[8];
            4'd9:    pat = SEG_TABLE[9];
            default: pat = '0;
        endcase
        return pat;
    endfunction

    // Tens of a value up to 99: multiply by 205/2048.
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [CLAMP_W-1:0] v);
        logic [14:0] prod;
        prod = {8'b0, v} * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [DIGIT_W-1:0] units_of(input logic [CLAMP_W-1:0] v,
                                                    input logic [DIGIT_W-1:0] tens);
        logic [CLAMP_W-1:0] rem;
        rem = v - {tens, 3'b000} - {2'b00, tens, 1'b0};
        return rem[DIGIT_W-1:0];
    endfunction

endpackage

>>> rtl/two_digit_seven_segment_scanner_core.sv
`timescale 1ns / 1ps
// Channel   | Handshake             | Payload
// ----------+-----------------------+-----------------------------------------------
// cfg       | cfg_valid / cfg_ready | cfg_data (refresh interval)
// in        | in_valid / in_ready   | now_time, display_value, dot_left, dot_right
// out       | out_valid / out_ready | refreshed, tens/units_enable_level,
//           |                       | segment_levels, dot_level
//
// One request per clock sustained while out_ready holds; a request goes from
// the input register, which the compare reads, to the output register.
// The input register refills in the same cycle it drains, so a stalled
// output only stops intake once both registers hold a request.
// Reset restores the default interval, clears the valid flags, the timer mark
// and the digit toggle, and blanks the drive; cfg_ready stays high, write only idle.

module two_digit_seven_segment_scanner_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tdss_pkg::TIME_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tdss_pkg::TIME_W-1:0]         now_time,
    input  logic [tdss_pkg::VALUE_W-1:0]        display_value,
    input  logic                                dot_left,
    input  logic                                dot_right,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                refreshed,
    output logic                                tens_enable_level,
    output logic                                units_enable_level,
    output logic [tdss_pkg::SEG_W-1:0]          segment_levels,
    output logic                                dot_level
);
    import tdss_pkg::*;

    // Configuration
    logic [TIME_W-1:0]  interval_reg;

    // Input register
    logic               in_full_reg;
    logic [TIME_W-1:0]  now_time_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               dot_left_reg;
    logic               dot_right_reg;

    // Scan state; the held drive levels double as the output payload
    logic [TIME_W-1:0]  last_refresh_reg;
    logic [TIME_W-1:0]  last_refresh_next;
    logic               next_is_units_reg;
    logic               next_is_units_next;
    logic               out_valid_reg;
    logic               refreshed_reg;
    logic               tens_en_reg;
    logic               tens_en_next;
    logic               units_en_reg;
    logic               units_en_next;
    logic [SEG_W-1:0]   seg_reg;
    logic [SEG_W-1:0]   seg_next;
    logic               dot_reg;
    logic               dot_next;

    logic               advance;
    logic [TIME_W-1:0]  elapsed;
    logic               fire;
    logic [CLAMP_W-1:0] clamped;
    logic [DIGIT_W-1:0] tens_digit;
    logic [DIGIT_W-1:0] units_digit;
    logic [DIGIT_W-1:0] shown_digit;

    // Move the buffered request into the output stage when the stage is free
    // or is being drained this cycle.
    assign advance  = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;
    assign cfg_ready = 1'b1;

    // Modular elapsed time keeps the scan going across counter wrap.
    assign elapsed = now_time_reg - last_refresh_reg;
    assign fire    = elapsed > interval_reg;

    // Clamp to 99 and split into decimal digits.
    assign clamped     = (value_reg > VALUE_MAX) ? VALUE_MAX[CLAMP_W-1:0]
                                                 : value_reg[CLAMP_W-1:0];
    assign tens_digit  = tens_of(clamped);
    assign units_digit = units_of(clamped, tens_digit);
    assign shown_digit = next_is_units_reg ? units_digit : tens_digit;

    always_comb
    begin
        last_refresh_next  = last_refresh_reg;
        next_is_units_next = next_is_units_reg;
        tens_en_next       = tens_en_reg;
        units_en_next      = units_en_reg;
        seg_next           = seg_reg;
        dot_next           = dot_reg;
        if (advance && fire)
        begin
            last_refresh_next  = now_time_reg;
            next_is_units_next = !next_is_units_reg;
            tens_en_next       = !next_is_units_reg;
            units_en_next      = next_is_units_reg;
            seg_next           = ~seg_pattern(shown_digit);
            // Active-low dot: drop the level to light it.
            dot_next           = next_is_units_reg ? !dot_right_reg : !dot_left_reg;
        end
    end

    // Control and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg      <= INTERVAL_RESET;
            in_full_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            last_refresh_reg  <= '0;
            next_is_units_reg <= 1'b0;
            tens_en_reg       <= 1'b0;
            units_en_reg      <= 1'b0;
            seg_reg           <= SEG_DARK;
            dot_reg           <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                interval_reg <= cfg_data;
            end
            if (in_valid && in_ready)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            last_refresh_reg  <= last_refresh_next;
            next_is_units_reg <= next_is_units_next;
            tens_en_reg       <= tens_en_next;
            units_en_reg      <= units_en_next;
            seg_reg           <= seg_next;
            dot_reg           <= dot_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_time_reg  <= now_time;
            value_reg     <= display_value;
            dot_left_reg  <= dot_left;
            dot_right_reg <= dot_right;
        end
        if (advance)
        begin
            refreshed_reg <= fire;
        end
    end

    assign out_valid          = out_valid_reg;
    assign refreshed          = refreshed_reg;
    assign tens_enable_level  = tens_en_reg;
    assign units_enable_level = units_en_reg;
    assign segment_levels     = seg_reg;
    assign dot_level          = dot_reg;

endmodule

>>> rtl/tdss_checker.sv
`timescale 1ns / 1ps
`include "two_digit_seven_segment_scanner_core_defines.svh"

module tdss_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         refreshed,
    input logic                         tens_enable_level,
    input logic                         units_enable_level,
    input logic [tdss_pkg::SEG_W-1:0]   segment_levels,
    input logic                         dot_level
);
    import tdss_pkg::*;

    // A stalled result keeps its drive levels.
    `TDSS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(segment_levels) && $stable(dot_level))

    // Never select both digits.
    `TDSS_ASSERT_IMPL(a_one_digit, clk, rst_n, out_valid, $onehot0({tens_enable_level, units_enable_level}))

    // A refresh always selects exactly one digit.
    `TDSS_ASSERT_IMPL(a_refresh_sel, clk, rst_n, out_valid && refreshed, $onehot({tens_enable_level, units_enable_level}))

    // Before the first refresh the display stays dark.
    `TDSS_ASSERT_IMPL(a_dark_idle, clk, rst_n, out_valid && !tens_enable_level && !units_enable_level, segment_levels == SEG_DARK && dot_level)

endmodule

bind two_digit_seven_segment_scanner_core tdss_checker u_tdss_checker (.*);

>>> bench/two_digit_seven_segment_scanner_core_test.sv
`timescale 1ns / 1ps

module two_digit_seven_segment_scanner_core_test;

    import tdss_pkg::TIME_W;
    import tdss_pkg::VALUE_W;
    import tdss_pkg::SEG_W;

    // Idle margin after the last result is back, before touching the interval
    // register or closing the run.
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_GAP       = 18;
    localparam int PHASE_TICKS   = 130;
    localparam int NUM_PHASES    = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIGIT_CAP     = 99;

    // Active-high glyphs for digits zero to nine.
    localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
        8'h77, 8'h06, 8'hB3, 8'h97, 8'hC6, 8'hD5, 8'hF5, 8'h07, 8'hF7, 8'hD7
    };

    // Interval for each random phase; the last one is drawn at run time.
    localparam logic [TIME_W-1:0] PHASE_INTERVAL [NUM_PHASES] = '{
        16'd1, 16'd0, 16'd3, 16'd40, 16'd65534, 16'd7, 16'd255, 16'd0
    };

    typedef enum logic { ROW_TICK, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic             refreshed;
        logic             tens_on;
        logic             units_on;
        logic [SEG_W-1:0] segments;
        logic             dot;
    } scan_out_t;

    // One line of the directed script. On a cfg row, stamp carries the
    // interval to write. The expected drive is only used where typed is set.
    typedef struct packed {
        row_kind_t          kind;
        logic [TIME_W-1:0]  stamp;
        logic [VALUE_W-1:0] value;
        logic               dot_l;
        logic               dot_r;
        logic               typed;
        scan_out_t          want;
    } script_row_t;

    localparam int SCRIPT_LEN = 25;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // reset interval: nothing refreshes up to and including 10000 ticks
        '{ROW_TICK, 16'd0,     8'd0,   1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 8'hFF, 1'b1}},
        '{ROW_TICK, 16'd10000, 8'd0,   1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 8'hFF, 1'b1}},
        // first refresh shows the tens of a clamped 255 with the left dot
        '{ROW_TICK, 16'd10001, 8'd255, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 8'h28, 1'b0}},
        '{ROW_TICK, 16'd20002, 8'd255, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, 8'h28, 1'b0}},
        '{ROW_TICK, 16'd20003, 8'd100, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h28, 1'b0}},
        // zero interval: any nonzero elapsed time switches digits
        '{ROW_CFG,  16'd0,     8'd0,   1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, 16'd20002, 8'd12,  1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h28, 1'b0}},
        '{ROW_TICK, 16'd20003, 8'd12,  1'b0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 8'hF9, 1'b1}},
        '{ROW_TICK, 16'd20004, 8'd12,  1'b0, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 8'h4C, 1'b1}},
        '{ROW_TICK, 16'd20005, 8'd99,  1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK, 16'd20006, 8'd99,  1'b0, 1'b1, 1'b0, '0},
        '{ROW_TICK, 16'd20007, 8'd45,  1'b1, 1'b1, 1'b0, '0},
        '{ROW_TICK, 16'd20008, 8'd67,  1'b1, 1'b1, 1'b0, '0},
        '{ROW_TICK, 16'd20009, 8'd38,  1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, 16'd20010, 8'd80,  1'b1, 1'b0, 1'b0, '0},
        // largest interval: the drive must freeze whatever the time does
        '{ROW_CFG,  16'd65535, 8'd0,   1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, 16'd0,     8'd7,   1'b1, 1'b1, 1'b0, '0},
        '{ROW_TICK, 16'd65535, 8'd255, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, 16'd20009, 8'd50,  1'b1, 1'b0, 1'b0, '0},
        // counter wrap: elapsed time is taken modulo 2^16
        '{ROW_CFG,  16'd5,     8'd0,   1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, 16'd65533, 8'd50,  1'b1, 1'b1, 1'b0, '0},
        '{ROW_TICK, 16'd2,     8'd51,  1'b0, 1'b1, 1'b0, '0},
        '{ROW_TICK, 16'd3,     8'd51,  1'b0, 1'b1, 1'b0, '0},
        // back to the reset interval
        '{ROW_CFG,  16'd10000, 8'd0,   1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, 16'd10004, 8'd63,  1'b1, 1'b0, 1'b0, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [TIME_W-1:0]  cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [TIME_W-1:0]  now_time;
    logic [VALUE_W-1:0] display_value;
    logic               dot_left;
    logic               dot_right;
    logic               out_valid;
    logic               out_ready;
    logic               refreshed;
    logic               tens_enable_level;
    logic               units_enable_level;
    logic [SEG_W-1:0]   segment_levels;
    logic               dot_level;

    two_digit_seven_segment_scanner_core u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .now_time           (now_time),
        .display_value      (display_value),
        .dot_left           (dot_left),
        .dot_right          (dot_right),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .refreshed          (refreshed),
        .tens_enable_level  (tens_enable_level),
        .units_enable_level (units_enable_level),
        .segment_levels     (segment_levels),
        .dot_level          (dot_level)
    );

    // Scanner state as the predictor sees it.
    logic [TIME_W-1:0] scan_interval;
    logic [TIME_W-1:0] scan_mark;
    logic              show_units_next;
    scan_out_t         drive;
    logic [TIME_W-1:0] last_stamp;

    // Drive levels still owed by the block, oldest first.
    scan_out_t owed_drive [$];

    int  mismatches;
    int  results_checked;
    int  ticks_sent;
    int  interval_writes;
    int  refresh_count;
    int  wrap_refreshes;
    int  clamped_ticks;
    bit  tx_calm;
    bit  rx_calm;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Fixed ceiling on the run: far past the slowest legal schedule.
    initial
    begin
        #(5_000_000);
        $display("timeout with %0d results still owed", owed_drive.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Bring the predictor to its post-reset state.
    function automatic void clear_scanner();
        scan_interval   = tdss_pkg::INTERVAL_RESET;
        scan_mark       = '0;
        show_units_next = 1'b0;
        drive           = '{1'b0, 1'b0, 1'b0, 8'hFF, 1'b1};
        last_stamp      = '0;
    endfunction

    // Advance the predictor by one tick and return the drive it should show.
    function automatic scan_out_t advance_scanner(input logic [TIME_W-1:0]  stamp,
                                                  input logic [VALUE_W-1:0] value,
                                                  input logic               dot_l,
                                                  input logic               dot_r);
        logic [TIME_W-1:0] since;
        int                shown;
        since = stamp - scan_mark;
        shown = (value > DIGIT_CAP) ? DIGIT_CAP : int'(value);
        if (value > DIGIT_CAP)
            clamped_ticks++;
        drive.refreshed = 1'b0;
        if (since > scan_interval)
        begin
            drive.refreshed = 1'b1;
            refresh_count++;
            if (stamp < scan_mark)
                wrap_refreshes++;
            scan_mark = stamp;
            if (!show_units_next)
            begin
                drive.tens_on  = 1'b1;
                drive.units_on = 1'b0;
                drive.segments = ~DIGIT_GLYPH[shown / 10];
                drive.dot      = ~dot_l;
            end
            else
            begin
                drive.tens_on  = 1'b0;
                drive.units_on = 1'b1;
                drive.segments = ~DIGIT_GLYPH[shown % 10];
                drive.dot      = ~dot_r;
            end
            show_units_next = ~show_units_next;
        end
        return drive;
    endfunction

    // Pick the next tick time: mostly small steps, with hits on both sides
    // of the refresh boundary and the odd jump anywhere in the counter.
    function automatic logic [TIME_W-1:0] pick_stamp();
        int reach;
        reach = (scan_interval > 500) ? 500 : 2 * int'(scan_interval) + 2;
        case ($urandom_range(0, 9))
            0:       return last_stamp;
            1:       return scan_mark + scan_interval;
            2:       return scan_mark + scan_interval + 16'd1;
            3:       return TIME_W'($urandom);
            default: return last_stamp + TIME_W'($urandom_range(0, reach));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return VALUE_W'($urandom_range(DIGIT_CAP + 1, 255));
        return VALUE_W'($urandom_range(0, DIGIT_CAP));
    endfunction

    // Offer one tick request and hold it until taken. On acceptance, run the
    // predictor and queue either the typed drive or the predicted one.
    task automatic send_tick(input logic [TIME_W-1:0]  stamp,
                             input logic [VALUE_W-1:0] value,
                             input logic               dot_l,
                             input logic               dot_r,
                             input logic               typed,
                             input scan_out_t          want);
        int        gap;
        scan_out_t predicted;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        now_time      <= stamp;
        display_value <= value;
        dot_left      <= dot_l;
        dot_right     <= dot_r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted  = advance_scanner(stamp, value, dot_l, dot_r);
        last_stamp = stamp;
        owed_drive.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_drive.size() != 0)
            @(posedge clk);
    endtask

    // Write the refresh interval once the block is idle.
    task automatic write_interval(input logic [TIME_W-1:0] interval);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= interval;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        scan_interval = interval;
        interval_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Compare one taken result against the oldest owed drive.
    task automatic check_drive(input scan_out_t seen);
        scan_out_t owed;
        results_checked++;
        if (owed_drive.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: result with nothing owed: ref=%0b ten=%0b unit=%0b seg=%02h dot=%0b",
                         $realtime, seen.refreshed, seen.tens_on, seen.units_on,
                         seen.segments, seen.dot);
        end
        else
        begin
            owed = owed_drive.pop_front();
            if (seen !== owed)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: expected ref=%0b ten=%0b unit=%0b seg=%02h dot=%0b",
                             $realtime, owed.refreshed, owed.tens_on, owed.units_on,
                             owed.segments, owed.dot);
                    $display("%0t:   actual ref=%0b ten=%0b unit=%0b seg=%02h dot=%0b",
                             $realtime, seen.refreshed, seen.tens_on, seen.units_on,
                             seen.segments, seen.dot);
                end
            end
        end
    endtask

    // Receiver: stall out_ready by a fresh random count for every result,
    // with calm stretches where it stays high throughout.
    initial
    begin
        int        gap;
        scan_out_t seen;
        int        taken;
        out_ready <= 1'b0;
        rx_calm   = 1'b0;
        taken     = 0;
        @(posedge clk);
        forever
        begin
            gap = draw_gap(rx_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            seen = '{refreshed, tens_enable_level, units_enable_level, segment_levels, dot_level};
            check_drive(seen);
            taken++;
            if (taken % 37 == 0)
                rx_calm = ~rx_calm;
        end
    end

    // Stimulus: reset, the directed script, then random phases.
    initial
    begin
        logic [TIME_W-1:0] interval;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        now_time      <= '0;
        display_value <= '0;
        dot_left      <= 1'b0;
        dot_right     <= 1'b0;
        mismatches      = 0;
        results_checked = 0;
        ticks_sent      = 0;
        interval_writes = 0;
        refresh_count   = 0;
        wrap_refreshes  = 0;
        clamped_ticks   = 0;
        tx_calm         = 1'b0;
        clear_scanner();

        // Hold reset, then release on an edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed script.
        for (int r = 0; r < SCRIPT_LEN; r++)
        begin
            if (SCRIPT[r].kind == ROW_CFG)
                write_interval(SCRIPT[r].stamp);
            else
                send_tick(SCRIPT[r].stamp, SCRIPT[r].value, SCRIPT[r].dot_l,
                          SCRIPT[r].dot_r, SCRIPT[r].typed, SCRIPT[r].want);
        end

        // Random phases, each under its own interval setting.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            interval = (p == NUM_PHASES - 1) ? TIME_W'($urandom) : PHASE_INTERVAL[p];
            write_interval(interval);
            for (int k = 0; k < PHASE_TICKS; k++)
            begin
                // Now and then let the pipe run dry before the next request.
                if ((p == 0 && k == 60) || $urandom_range(0, 99) == 0)
                    hold_until_drained();
                if ($urandom_range(0, 39) == 0)
                    tx_calm = ~tx_calm;
                send_tick(pick_stamp(), pick_value(), 1'($urandom), 1'($urandom), 1'b0, '0);
            end
        end

        // Drain, then give stray results a chance to show up.
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d ticks under %0d interval writes; %0d digit switches, %0d across a wrap.",
                 ticks_sent, interval_writes, refresh_count, wrap_refreshes);
        $display("%0d ticks carried values above 99; %0d results checked, %0d mismatches.",
                 clamped_ticks, results_checked, mismatches);
        if (mismatches == 0 && owed_drive.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tdss_pkg.sv
rtl/two_digit_seven_segment_scanner_core.sv
rtl/tdss_checker.sv
bench/two_digit_seven_segment_scanner_core_test.sv
